// ===== hdl/vfv_pkg.sv =====
// Shared types, codes and helpers for the voxel face visibility block.
package vfv_pkg;

  localparam int CodeW  = 8;
  localparam int CoordW = 4;
  localparam int CsizeW = 5;
  localparam int FaceN  = 6;

  // op codes carried in s_axis_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_CHUNK_SIZE = 2'd0;
  localparam logic [1:0] CFG_GRASS_CODE = 2'd1;
  localparam logic [1:0] CFG_STONE_CODE = 2'd2;

  // face order in face_mask
  localparam int FACE_PX = 0;
  localparam int FACE_NX = 1;
  localparam int FACE_PZ = 2;
  localparam int FACE_NZ = 3;
  localparam int FACE_NY = 4;
  localparam int FACE_PY = 5;

  // classified item handed from front to back
  typedef struct packed {
    logic                op;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [CoordW-1:0]   z;
    logic [CodeW-1:0]    code;
    logic                cell_in;
    logic [FaceN-1:0]    nbr_in;
  } entry_t;

  function automatic logic code_filled(input logic [CodeW-1:0] code,
                                       input logic [CodeW-1:0] grass,
                                       input logic [CodeW-1:0] stone);
    return (code == grass) || (code == stone);
  endfunction

endpackage

// ===== hdl/vfv_ram.sv =====
// Generic single-port RAM with registered read data.
module vfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vfv_front.sv =====
// Front end: accepts items and classifies the cell and its neighbors against the chunk.
module vfv_front #(
  parameter int MAX_EDGE = 16
) (
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [23:0]                s_data_i,
  input  logic                       s_user_i,
  input  logic [vfv_pkg::CsizeW-1:0] chunk_size_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output vfv_pkg::entry_t            entry_o
);

  localparam int EW = $clog2(MAX_EDGE + 1);
  localparam int CW = (EW > vfv_pkg::CsizeW) ? EW : vfv_pkg::CsizeW;

  logic [CW-1:0] edge_len;
  logic [CW-1:0] xe, ye, ze;
  logic [vfv_pkg::CoordW-1:0] x, y, z;

  assign x = s_data_i[3:0];
  assign y = s_data_i[7:4];
  assign z = s_data_i[11:8];
  assign xe = CW'(x);
  assign ye = CW'(y);
  assign ze = CW'(z);

  // chunk size saturates at the grid edge
  assign edge_len = (CW'(chunk_size_i) > CW'(MAX_EDGE)) ? CW'(MAX_EDGE) : CW'(chunk_size_i);

  always_comb begin
    entry_o.op      = s_user_i;
    entry_o.x       = x;
    entry_o.y       = y;
    entry_o.z       = z;
    entry_o.code    = s_data_i[19:12];
    entry_o.cell_in = (xe < edge_len) && (ye < edge_len) && (ze < edge_len);
    entry_o.nbr_in[vfv_pkg::FACE_PX] = (xe + CW'(1)) < edge_len;
    entry_o.nbr_in[vfv_pkg::FACE_NX] = x != '0;
    entry_o.nbr_in[vfv_pkg::FACE_PZ] = (ze + CW'(1)) < edge_len;
    entry_o.nbr_in[vfv_pkg::FACE_NZ] = z != '0;
    entry_o.nbr_in[vfv_pkg::FACE_NY] = y != '0;
    entry_o.nbr_in[vfv_pkg::FACE_PY] = (ye + CW'(1)) < edge_len;
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

// ===== hdl/vfv_queue.sv =====
// Two-entry queue between front and back.
module vfv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vfv_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vfv_pkg::entry_t head_o
);

  vfv_pkg::entry_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        slot_q[wr_ptr_q] <= entry_i;
        wr_ptr_q         <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = slot_q[rd_ptr_q];

endmodule

// ===== hdl/vfv_back.sv =====
// Back end: grid memory sequencing, face mask build and output register.
module vfv_back #(
  parameter int MAX_EDGE = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  vfv_pkg::entry_t           head_i,
  output logic                      pop_o,
  input  logic [vfv_pkg::CodeW-1:0] grass_code_i,
  input  logic [vfv_pkg::CodeW-1:0] stone_code_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [15:0]               m_data_o
);

  localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] STEP_X = AW'(MAX_EDGE * MAX_EDGE);
  localparam logic [AW-1:0] STEP_Z = AW'(MAX_EDGE);
  localparam logic [AW-1:0] STEP_Y = AW'(1);
  localparam logic [2:0]    LAST_K = 3'(vfv_pkg::FaceN);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_LAST} state_e;

  state_e                    state_q;
  logic [2:0]                k_q, sel, rd_idx_q;
  logic                      rd_pend_q;
  vfv_pkg::entry_t           ent_q, cur;
  logic [vfv_pkg::CodeW-1:0] code_q, code_d, rdata;
  logic [vfv_pkg::FaceN-1:0] nbr_q, nbr_d;
  logic                      m_valid_q;
  logic [15:0]               m_data_q, result;
  logic [AW-1:0]             base, addr;
  logic                      we, re, out_load, fill, tex;

  assign cur  = (state_q == S_IDLE) ? head_i : ent_q;
  assign sel  = (state_q == S_IDLE) ? 3'd0 : k_q;
  assign base = AW'((AW'(cur.x) * STEP_Z + AW'(cur.z)) * STEP_Z + AW'(cur.y));

  // sel 0 is the cell itself, 1..6 the faces in mask order
  always_comb begin
    case (sel)
      3'd1:    addr = base + STEP_X;
      3'd2:    addr = base - STEP_X;
      3'd3:    addr = base + STEP_Z;
      3'd4:    addr = base - STEP_Z;
      3'd5:    addr = base - STEP_Y;
      3'd6:    addr = base + STEP_Y;
      default: addr = base;
    endcase
  end

  assign pop_o = (state_q == S_IDLE) && q_valid_i;
  assign we    = pop_o && head_i.cell_in && (head_i.op == vfv_pkg::OP_WRITE);

  always_comb begin
    if (state_q == S_IDLE) begin
      re = pop_o && head_i.cell_in && (head_i.op == vfv_pkg::OP_QUERY);
    end else if (state_q == S_RD) begin
      // neighbors outside the chunk are not read
      re = (k_q == 3'd0) || ent_q.nbr_in[k_q - 3'd1];
    end else begin
      re = 1'b0;
    end
  end

  vfv_ram #(
    .WIDTH (vfv_pkg::CodeW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (head_i.code),
    .rdata_o (rdata)
  );

  always_comb begin
    code_d = code_q;
    nbr_d  = nbr_q;
    if (pop_o) begin
      code_d = '0;
      nbr_d  = '0;
    end else if (rd_pend_q) begin
      if (rd_idx_q == 3'd0) begin
        code_d = rdata;
      end else begin
        nbr_d[rd_idx_q - 3'd1] = vfv_pkg::code_filled(rdata, grass_code_i, stone_code_i);
      end
    end
    fill   = ent_q.cell_in && vfv_pkg::code_filled(code_d, grass_code_i, stone_code_i);
    tex    = ent_q.cell_in && (code_d == stone_code_i);
    // stored_code[15:8], texture_select[7], face_mask[6:1], filled[0]
    result = {ent_q.cell_in ? code_d : 8'd0, tex, fill ? ~nbr_d : 6'd0, fill};
  end

  assign out_load = (state_q == S_LAST) && (!m_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= 3'd0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= 3'd0;
      m_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= re;
      rd_idx_q  <= sel;
      code_q    <= code_d;
      nbr_q     <= nbr_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= result;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            ent_q <= head_i;
            if (!head_i.cell_in) begin
              state_q <= S_LAST;
            end else if (head_i.op == vfv_pkg::OP_WRITE) begin
              k_q     <= 3'd0;
              state_q <= S_RD;
            end else begin
              k_q     <= 3'd1;
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          k_q <= k_q + 3'd1;
          if (k_q == LAST_K) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !re) else $error("grid write and read in one cycle");
  a_return_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_RD || state_q == S_LAST))
    else $error("read data returned outside the read sequence");
  a_mask_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[0]) |-> (m_data_q[6:1] == 6'd0))
    else $error("face mask set on an unfilled cell");
  a_tex_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[7]) |-> m_data_q[0])
    else $error("stone texture on an unfilled cell");
`endif

endmodule

// ===== hdl/voxel_face_visibility.sv =====
// Top level of the voxel face visibility block: config registers, front, queue, back.
//
// Each item is a write or a query of one cell of a MAX_EDGE^3 grid of 8-bit codes and
// yields one result beat. All grid traffic goes through one single-port memory, one access
// per cycle: a query reads the cell, then its neighbors in the chunk; a write does the same
// after storing its code; an item outside the chunk does no reads. A two-entry queue takes
// new beats while the back end works; the result register holds a finished beat while the
// next item runs. Configuration must be written only while idle; the block never checks.
module voxel_face_visibility #(
  parameter int MAX_EDGE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cell_x[3:0], cell_y[7:4], cell_z[11:8], block_code[19:12]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // filled[0], face_mask[6:1], texture_select[7],
                                     // stored_code[15:8]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [vfv_pkg::CsizeW-1:0] chunk_size_q;
  logic [vfv_pkg::CodeW-1:0]  grass_code_q, stone_code_q;
  logic                       push, q_full, q_valid, pop;
  vfv_pkg::entry_t            entry, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= 5'd16;
      grass_code_q <= 8'd1;
      stone_code_q <= 8'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vfv_pkg::CFG_CHUNK_SIZE: chunk_size_q <= cfg_data_i[vfv_pkg::CsizeW-1:0];
        vfv_pkg::CFG_GRASS_CODE: grass_code_q <= cfg_data_i;
        vfv_pkg::CFG_STONE_CODE: stone_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vfv_front #(
    .MAX_EDGE (MAX_EDGE)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .chunk_size_i (chunk_size_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (entry)
  );

  vfv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  vfv_back #(
    .MAX_EDGE (MAX_EDGE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .grass_code_i (grass_code_q),
    .stone_code_i (stone_code_q),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata)
  );

endmodule
